// File: design/w2h_pkg.sv
// Shared types and constants for the weighted two-dimensional histogram.
// Holds the command codes, register indexes, queue entry format and back-end states.
// No dependencies.
`timescale 1ns / 1ps

package w2h_pkg;

    localparam int DEF_MAX_COLS = 64;
    localparam int DEF_MAX_ROWS = 64;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int SAMPLE_W   = 16;
    localparam int BIN_IDX_W  = 6;
    localparam int VALUE_W    = 32;
    localparam int ADDEND_W   = SAMPLE_W + 1;
    localparam int PROD_W     = 2 * ADDEND_W;
    localparam int LIM_W      = 11;

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = 2;

    typedef enum logic [1:0] {
        FUNC_ACC      = 2'd0,
        FUNC_READ     = 2'd1,
        FUNC_READ_CLR = 2'd2
    } t_func;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MIN_A      = 3'd0,
        REG_INV_STEP_A = 3'd1,
        REG_BINS_A     = 3'd2,
        REG_MIN_B      = 3'd3,
        REG_INV_STEP_B = 3'd4,
        REG_BINS_B     = 3'd5,
        REG_WEIGHTED   = 3'd6
    } t_cfg_reg;

    typedef struct packed {
        t_func                        func;
        logic [BIN_IDX_W-1:0]         col;
        logic [BIN_IDX_W-1:0]         row;
        logic signed [ADDEND_W-1:0]   addend;
    } t_cmd;

    typedef enum logic [1:0] {
        B_CLEAR,
        B_IDLE,
        B_READ,
        B_WRITE
    } t_back_state;

endpackage

// File: design/weighted_2d_histogram.sv
// Weighted two-dimensional histogram with saturating 32-bit bins.
// Input side is a queue write port: an item is taken when push is high and full low.
// Function 0 bins a sample pair and adds one or the weight; function 1 reads a bin;
// function 2 reads a bin and clears it; code 3 is dropped without effect.
// Results come out of a queue read port: the oldest result is valid while empty is low
// and is taken when pop is high.
// After reset a clearing pass zeroes the MAX_COLS * MAX_ROWS bins, one per cycle;
// full stays high until it has finished.
// Configuration writes through i_cfg_we/i_cfg_idx/i_cfg_data take effect at once; the user
// must make them while the block is idle, as the block itself does not enforce this.
// The back end takes each item through memory read, registered data and write back, and
// takes no new item from the queue until its write back is done; the front end and a
// four-entry queue keep accepting meanwhile.
// While the result register is waiting to be popped, a read at the head of the queue waits
// and so does every item behind it; full rises once the queue and product stage are full.
// Depends on w2h_pkg, w2h_front, w2h_queue and w2h_back.
`timescale 1ns / 1ps

module weighted_2d_histogram
    import w2h_pkg::*;
#(
    parameter int MAX_COLS = DEF_MAX_COLS,
    parameter int MAX_ROWS = DEF_MAX_ROWS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]       i_cfg_data,
    input  logic                        push,
    output logic                        full,
    input  logic [1:0]                  i_func,
    input  logic signed [SAMPLE_W-1:0]  i_sample_a,
    input  logic signed [SAMPLE_W-1:0]  i_sample_b,
    input  logic signed [SAMPLE_W-1:0]  i_weight,
    input  logic [BIN_IDX_W-1:0]        i_read_col,
    input  logic [BIN_IDX_W-1:0]        i_read_row,
    output logic                        empty,
    input  logic                        pop,
    output logic signed [VALUE_W-1:0]   o_bin_value,
    output logic [BIN_IDX_W-1:0]        o_out_col,
    output logic [BIN_IDX_W-1:0]        o_out_row
);

    t_cmd front_cmd, q_cmd;
    logic front_push, q_full, q_empty, q_pop, clearing;

    w2h_front #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_push     (push),
        .o_full     (full),
        .i_func     (i_func),
        .i_sample_a (i_sample_a),
        .i_sample_b (i_sample_b),
        .i_weight   (i_weight),
        .i_read_col (i_read_col),
        .i_read_row (i_read_row),
        .i_hold     (clearing),
        .i_q_full   (q_full),
        .o_q_push   (front_push),
        .o_cmd      (front_cmd)
    );

    w2h_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_cmd   (front_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_cmd   (q_cmd),
        .o_empty (q_empty)
    );

    w2h_back #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (q_cmd),
        .i_q_empty   (q_empty),
        .o_q_pop     (q_pop),
        .o_clearing  (clearing),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_bin_value (o_bin_value),
        .o_out_col   (o_out_col),
        .o_out_row   (o_out_row)
    );

endmodule

// File: design/w2h_front.sv
// Front end of the histogram: configuration registers, input stage and bin classification.
// Turns each accepted item into a queue command with final column, row and addend.
// Depends on w2h_pkg.
`timescale 1ns / 1ps

module w2h_front
    import w2h_pkg::*;
#(
    parameter int MAX_COLS = DEF_MAX_COLS,
    parameter int MAX_ROWS = DEF_MAX_ROWS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]       i_cfg_data,
    input  logic                        i_push,
    output logic                        o_full,
    input  logic [1:0]                  i_func,
    input  logic signed [SAMPLE_W-1:0]  i_sample_a,
    input  logic signed [SAMPLE_W-1:0]  i_sample_b,
    input  logic signed [SAMPLE_W-1:0]  i_weight,
    input  logic [BIN_IDX_W-1:0]        i_read_col,
    input  logic [BIN_IDX_W-1:0]        i_read_row,
    input  logic                        i_hold,
    input  logic                        i_q_full,
    output logic                        o_q_push,
    output t_cmd                        o_cmd
);

    localparam logic [LIM_W-1:0] COL_LIM = LIM_W'(MAX_COLS - 1);
    localparam logic [LIM_W-1:0] ROW_LIM = LIM_W'(MAX_ROWS - 1);

    // Configuration registers
    logic signed [SAMPLE_W-1:0] r_min_a, r_min_b;
    logic [SAMPLE_W-1:0]        r_inv_a, r_inv_b;
    logic [BIN_IDX_W-1:0]       r_bins_a, r_bins_b;
    logic                       r_weighted;

    // Input stage
    logic                       r_f1_valid;
    logic [1:0]                 r_f1_func;
    logic signed [SAMPLE_W-1:0] r_f1_sa, r_f1_sb, r_f1_w;
    logic [BIN_IDX_W-1:0]       r_f1_rc, r_f1_rr;

    // Product stage
    logic                       r_f2_valid;
    t_func                      r_f2_func;
    logic signed [PROD_W-1:0]   r_f2_prod_a, r_f2_prod_b;
    logic signed [ADDEND_W-1:0] r_f2_addend;
    logic [BIN_IDX_W-1:0]       r_f2_rc, r_f2_rr;

    logic                       front_en;
    logic                       accept;
    logic                       f1_func_ok;
    logic signed [ADDEND_W-1:0] diff_a, diff_b;
    logic signed [PROD_W-1:0]   prod_a, prod_b;
    logic signed [ADDEND_W-1:0] addend;
    logic [BIN_IDX_W-1:0]       acc_col, acc_row;

    function automatic logic [BIN_IDX_W-1:0] axis_idx(
        input logic signed [PROD_W-1:0] prod,
        input logic [BIN_IDX_W-1:0]     last
    );
        logic [PROD_W-9:0] idx;
        idx = prod[PROD_W-1:8];
        if (prod < 0) begin
            return '0;
        end else if (idx > (PROD_W-8)'(last)) begin
            return last;
        end else begin
            return idx[BIN_IDX_W-1:0];
        end
    endfunction

    function automatic logic [BIN_IDX_W-1:0] lim_idx(
        input logic [BIN_IDX_W-1:0] v,
        input logic [LIM_W-1:0]     lim
    );
        if (LIM_W'(v) > lim) begin
            return lim[BIN_IDX_W-1:0];
        end else begin
            return v;
        end
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_a    <= '0;
            r_min_b    <= '0;
            r_inv_a    <= SAMPLE_W'(256);
            r_inv_b    <= SAMPLE_W'(256);
            r_bins_a   <= BIN_IDX_W'(63);
            r_bins_b   <= BIN_IDX_W'(63);
            r_weighted <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_idx))
                REG_MIN_A:      r_min_a    <= i_cfg_data;
                REG_INV_STEP_A: r_inv_a    <= i_cfg_data;
                REG_BINS_A:     r_bins_a   <= i_cfg_data[BIN_IDX_W-1:0];
                REG_MIN_B:      r_min_b    <= i_cfg_data;
                REG_INV_STEP_B: r_inv_b    <= i_cfg_data;
                REG_BINS_B:     r_bins_b   <= i_cfg_data[BIN_IDX_W-1:0];
                REG_WEIGHTED:   r_weighted <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // The whole front moves together; it stalls only when the product stage
    // holds an item that the queue cannot take.
    assign front_en = !r_f2_valid || !i_q_full;
    assign o_full   = i_hold || !front_en;
    assign accept   = i_push && !o_full;
    assign o_q_push = r_f2_valid && !i_q_full;

    assign f1_func_ok = (r_f1_func == FUNC_ACC) || (r_f1_func == FUNC_READ) ||
                        (r_f1_func == FUNC_READ_CLR);

    assign diff_a = ADDEND_W'(r_f1_sa) - ADDEND_W'(r_min_a);
    assign diff_b = ADDEND_W'(r_f1_sb) - ADDEND_W'(r_min_b);
    assign prod_a = PROD_W'(diff_a) * PROD_W'($signed({1'b0, r_inv_a}));
    assign prod_b = PROD_W'(diff_b) * PROD_W'($signed({1'b0, r_inv_b}));
    assign addend = r_weighted ? ADDEND_W'(r_f1_w) : ADDEND_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_valid <= 1'b0;
            r_f2_valid <= 1'b0;
        end else if (front_en) begin
            r_f1_valid <= accept;
            r_f2_valid <= r_f1_valid && f1_func_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (front_en) begin
            r_f1_func   <= i_func;
            r_f1_sa     <= i_sample_a;
            r_f1_sb     <= i_sample_b;
            r_f1_w      <= i_weight;
            r_f1_rc     <= i_read_col;
            r_f1_rr     <= i_read_row;
            r_f2_func   <= t_func'(r_f1_func);
            r_f2_prod_a <= prod_a;
            r_f2_prod_b <= prod_b;
            r_f2_addend <= addend;
            r_f2_rc     <= r_f1_rc;
            r_f2_rr     <= r_f1_rr;
        end
    end

    assign acc_col = lim_idx(axis_idx(r_f2_prod_a, r_bins_a), COL_LIM);
    assign acc_row = lim_idx(axis_idx(r_f2_prod_b, r_bins_b), ROW_LIM);

    always_comb begin
        o_cmd.func   = r_f2_func;
        o_cmd.addend = r_f2_addend;
        if (r_f2_func == FUNC_ACC) begin
            o_cmd.col = acc_col;
            o_cmd.row = acc_row;
        end else begin
            o_cmd.col = lim_idx(r_f2_rc, COL_LIM);
            o_cmd.row = lim_idx(r_f2_rr, ROW_LIM);
        end
    end

endmodule

// File: design/w2h_queue.sv
// Short command queue between the histogram front and back ends.
// Depends on w2h_pkg for the command format and depth.
`timescale 1ns / 1ps

module w2h_queue
    import w2h_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output t_cmd o_cmd,
    output logic o_empty
);

    t_cmd               r_slot [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [Q_PTR_W:0]   r_count;

    assign o_full  = (r_count == (Q_PTR_W+1)'(Q_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

// File: design/w2h_back.sv
// Back end of the histogram: the bin memory, its clearing pass after reset,
// the read-modify-write sequencer and the result register. Depends on w2h_pkg.
`timescale 1ns / 1ps

module w2h_back
    import w2h_pkg::*;
#(
    parameter int MAX_COLS = DEF_MAX_COLS,
    parameter int MAX_ROWS = DEF_MAX_ROWS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_cmd                       i_cmd,
    input  logic                       i_q_empty,
    output logic                       o_q_pop,
    output logic                       o_clearing,
    output logic                       o_empty,
    input  logic                       i_pop,
    output logic signed [VALUE_W-1:0]  o_bin_value,
    output logic [BIN_IDX_W-1:0]       o_out_col,
    output logic [BIN_IDX_W-1:0]       o_out_row
);

    localparam int DEPTH  = MAX_COLS * MAX_ROWS;
    localparam int ADDR_W = $clog2(DEPTH);

    logic [VALUE_W-1:0]         r_mem [DEPTH];
    t_back_state                r_state, n_state;
    logic [ADDR_W-1:0]          r_clr_addr;
    logic [ADDR_W-1:0]          r_addr;
    t_func                      r_op;
    logic [BIN_IDX_W-1:0]       r_col, r_row;
    logic signed [ADDEND_W-1:0] r_addend;
    logic [VALUE_W-1:0]         r_rdata;
    logic                       r_out_valid;
    logic [VALUE_W-1:0]         r_out_value;
    logic [BIN_IDX_W-1:0]       r_out_col, r_out_row;

    logic                       issue;
    logic                       we;
    logic [ADDR_W-1:0]          waddr;
    logic [VALUE_W-1:0]         wdata;
    logic signed [VALUE_W:0]    sum;
    logic [VALUE_W-1:0]         sat_sum;

    // A read command may start only when its result has a free place to go.
    assign issue = (r_state == B_IDLE) && !i_q_empty &&
                   ((i_cmd.func == FUNC_ACC) || !r_out_valid || i_pop);
    assign o_q_pop    = issue;
    assign o_clearing = (r_state == B_CLEAR);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            B_CLEAR: begin
                if (r_clr_addr == ADDR_W'(DEPTH - 1)) begin
                    n_state = B_IDLE;
                end
            end
            B_IDLE: begin
                if (issue) begin
                    n_state = B_READ;
                end
            end
            B_READ:  n_state = B_WRITE;
            B_WRITE: n_state = B_IDLE;
            default: n_state = B_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= B_CLEAR;
            r_clr_addr <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == B_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_addr   <= ADDR_W'(ADDR_W'(i_cmd.col) * ADDR_W'(MAX_ROWS)) + ADDR_W'(i_cmd.row);
            r_op     <= i_cmd.func;
            r_col    <= i_cmd.col;
            r_row    <= i_cmd.row;
            r_addend <= i_cmd.addend;
        end
    end

    // Saturate when the carry into the sign bit disagrees with the sign.
    assign sum = (VALUE_W+1)'($signed(r_rdata)) + (VALUE_W+1)'(r_addend);
    always_comb begin
        if (sum[VALUE_W] != sum[VALUE_W-1]) begin
            sat_sum = {sum[VALUE_W], {(VALUE_W-1){!sum[VALUE_W]}}};
        end else begin
            sat_sum = sum[VALUE_W-1:0];
        end
    end

    always_comb begin
        we    = 1'b0;
        waddr = r_addr;
        wdata = '0;
        if (r_state == B_CLEAR) begin
            we    = 1'b1;
            waddr = r_clr_addr;
        end else if (r_state == B_WRITE && r_op != FUNC_READ) begin
            we = 1'b1;
            if (r_op == FUNC_ACC) begin
                wdata = sat_sum;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= wdata;
        end
        r_rdata <= r_mem[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == B_WRITE && r_op != FUNC_ACC) begin
            r_out_valid <= 1'b1;
        end else if (i_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == B_WRITE && r_op != FUNC_ACC) begin
            r_out_value <= r_rdata;
            r_out_col   <= r_col;
            r_out_row   <= r_row;
        end
    end

    assign o_empty     = !r_out_valid;
    assign o_bin_value = $signed(r_out_value);
    assign o_out_col   = r_out_col;
    assign o_out_row   = r_out_row;

endmodule

// File: verif/weighted_2d_histogram_tb.sv
// Self-checking testbench for the weighted two-dimensional histogram.
// Items go in through a queue driver; bin reports are checked against an in-order predictor.
// Depends on w2h_pkg and weighted_2d_histogram.
`timescale 1ns / 1ps

module weighted_2d_histogram_tb;
    import w2h_pkg::*;

    localparam int COLS = DEF_MAX_COLS;
    localparam int ROWS = DEF_MAX_ROWS;
    localparam int DRAIN_CYCLES = 64;
    localparam int STALL_LIMIT  = 20000;
    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam longint SAT_HI = 64'sd2147483647;
    localparam longint SAT_LO = -64'sd2147483648;

    typedef struct packed {
        logic [1:0]                 func;
        logic signed [SAMPLE_W-1:0] sample_a;
        logic signed [SAMPLE_W-1:0] sample_b;
        logic signed [SAMPLE_W-1:0] weight;
        logic [BIN_IDX_W-1:0]       read_col;
        logic [BIN_IDX_W-1:0]       read_row;
        logic                       drain_first;
    } t_hist_cmd;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic [BIN_IDX_W-1:0]      col;
        logic [BIN_IDX_W-1:0]      row;
    } t_bin_report;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic push = 1'b0;
    logic pop = 1'b0;
    logic full;
    logic empty;
    t_hist_cmd in_flight = '0;
    logic signed [VALUE_W-1:0] o_bin_value;
    logic [BIN_IDX_W-1:0] o_out_col;
    logic [BIN_IDX_W-1:0] o_out_row;

    t_hist_cmd   cmd_backlog[$];
    t_bin_report bin_reports_due[$];
    t_bin_report oldest_report;

    // Predictor copy of the bins and the configuration.
    logic signed [VALUE_W-1:0] bin_counts [COLS*ROWS];
    logic signed [SAMPLE_W-1:0] lo_a = '0, lo_b = '0;
    logic [15:0] inv_a = 16'd256, inv_b = 16'd256;
    logic [BIN_IDX_W-1:0] last_a = 6'd63, last_b = 6'd63;
    logic weight_mode = 1'b0;

    int idle_pct = 25;
    int mismatches = 0;
    int stall_cycles = 0;

    weighted_2d_histogram dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .push        (push),
        .full        (full),
        .i_func      (in_flight.func),
        .i_sample_a  (in_flight.sample_a),
        .i_sample_b  (in_flight.sample_b),
        .i_weight    (in_flight.weight),
        .i_read_col  (in_flight.read_col),
        .i_read_row  (in_flight.read_row),
        .empty       (empty),
        .pop         (pop),
        .o_bin_value (o_bin_value),
        .o_out_col   (o_out_col),
        .o_out_row   (o_out_row)
    );

    always #5 clk = ~clk;

    function automatic int unsigned axis_bin(logic signed [SAMPLE_W-1:0] s,
                                             logic signed [SAMPLE_W-1:0] lo,
                                             logic [15:0] inv, logic [BIN_IDX_W-1:0] last);
        longint prod;
        prod = (longint'(s) - longint'(lo)) * longint'(inv);
        if (prod < 0) return 0;
        prod = prod >>> 8;
        return (prod > longint'(last)) ? int'(last) : int'(prod);
    endfunction

    function automatic void histogram_apply(t_hist_cmd c);
        int unsigned col, row;
        longint total;
        t_bin_report r;
        case (c.func)
            FUNC_ACC: begin
                col = axis_bin(c.sample_a, lo_a, inv_a, last_a);
                row = axis_bin(c.sample_b, lo_b, inv_b, last_b);
                if (col > COLS - 1) col = COLS - 1;
                if (row > ROWS - 1) row = ROWS - 1;
                total = longint'(bin_counts[col * ROWS + row])
                      + (weight_mode ? longint'(c.weight) : 64'sd1);
                if (total > SAT_HI) total = SAT_HI;
                if (total < SAT_LO) total = SAT_LO;
                bin_counts[col * ROWS + row] = total[31:0];
            end
            FUNC_READ, FUNC_READ_CLR: begin
                col = c.read_col;
                row = c.read_row;
                if (col > COLS - 1) col = COLS - 1;
                if (row > ROWS - 1) row = ROWS - 1;
                r.value = bin_counts[col * ROWS + row];
                r.col = col[BIN_IDX_W-1:0];
                r.row = row[BIN_IDX_W-1:0];
                bin_reports_due.push_back(r);
                if (c.func == FUNC_READ_CLR) bin_counts[col * ROWS + row] = '0;
            end
            default: ;
        endcase
    endfunction

    // Driver: an item is held on the ports until the block takes it.
    always @(posedge clk) begin
        if (!rst_n) begin
            push <= 1'b0;
        end else begin
            if (push && !full) histogram_apply(in_flight);
            if (!push || !full) begin
                if (cmd_backlog.size() != 0
                        && !(cmd_backlog[0].drain_first && bin_reports_due.size() != 0)
                        && $urandom_range(99) >= idle_pct) begin
                    in_flight <= cmd_backlog.pop_front();
                    push <= 1'b1;
                end else begin
                    push <= 1'b0;
                end
            end
        end
    end

    // Monitor: every report taken is matched against the oldest one predicted.
    always @(posedge clk) begin
        if (!rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (bin_reports_due.size() == 0) begin
                    $error("unexpected bin report: col %0d row %0d value %0d",
                           o_out_col, o_out_row, o_bin_value);
                    mismatches++;
                end else begin
                    oldest_report = bin_reports_due.pop_front();
                    if (o_bin_value !== oldest_report.value) begin
                        $error("bin_value: expected %0d, got %0d",
                               oldest_report.value, o_bin_value);
                        mismatches++;
                    end
                    if (o_out_col !== oldest_report.col) begin
                        $error("out_col: expected %0d, got %0d", oldest_report.col, o_out_col);
                        mismatches++;
                    end
                    if (o_out_row !== oldest_report.row) begin
                        $error("out_row: expected %0d, got %0d", oldest_report.row, o_out_row);
                        mismatches++;
                    end
                end
            end
            pop <= ($urandom_range(99) >= idle_pct);
        end
    end

    always @(posedge clk) begin
        if ((push && !full) || (pop && !empty)) stall_cycles <= 0;
        else stall_cycles <= stall_cycles + 1;
    end

    initial begin
        wait (stall_cycles >= STALL_LIMIT);
        $display("RESULT: ERROR");
        $finish;
    end

    task automatic cfg_write(t_cfg_reg idx, logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        case (idx)
            REG_MIN_A:      lo_a = data;
            REG_INV_STEP_A: inv_a = data;
            REG_BINS_A:     last_a = data[BIN_IDX_W-1:0];
            REG_MIN_B:      lo_b = data;
            REG_INV_STEP_B: inv_b = data;
            REG_BINS_B:     last_b = data[BIN_IDX_W-1:0];
            REG_WEIGHTED:   weight_mode = data[0];
            default: ;
        endcase
    endtask

    task automatic program_axes(int min_a, int step_a, int bins_a,
                                int min_b, int step_b, int bins_b, int wmode);
        cfg_write(REG_MIN_A, 16'(min_a));
        cfg_write(REG_INV_STEP_A, 16'(step_a));
        cfg_write(REG_BINS_A, 16'(bins_a));
        cfg_write(REG_MIN_B, 16'(min_b));
        cfg_write(REG_INV_STEP_B, 16'(step_b));
        cfg_write(REG_BINS_B, 16'(bins_b));
        cfg_write(REG_WEIGHTED, 16'(wmode));
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic queue_item(logic [1:0] func, int sa, int sb, int w, int col, int row);
        t_hist_cmd c;
        c.func = func;
        c.sample_a = 16'(sa);
        c.sample_b = 16'(sb);
        c.weight = 16'(w);
        c.read_col = 6'(col);
        c.read_row = 6'(row);
        c.drain_first = 1'b0;
        cmd_backlog.push_back(c);
    endtask

    // Waits until every item is in, every report is out, and accumulates have retired.
    task automatic settle();
        @(negedge clk);
        while (cmd_backlog.size() != 0 || push || bin_reports_due.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic random_setup();
        int mode;
        mode = $urandom_range(3);
        program_axes((mode == 0) ? int'($urandom) : int'($urandom_range(2000)) - 1000,
                     (mode == 0) ? int'($urandom) : int'($urandom_range(1024, 16)),
                     ($urandom_range(3) == 0) ? $urandom_range(63, 1) : $urandom_range(7, 1),
                     (mode == 1) ? int'($urandom) : int'($urandom_range(2000)) - 1000,
                     (mode == 1) ? int'($urandom) : int'($urandom_range(1024, 16)),
                     ($urandom_range(3) == 0) ? $urandom_range(63, 1) : $urandom_range(7, 1),
                     $urandom_range(1));
    endtask

    // Mostly samples that land inside the configured bins, so reads find real counts.
    task automatic random_items(int count);
        t_hist_cmd c;
        int span_a, span_b, pick;
        for (int n = 0; n < count; n++) begin
            span_a = ((int'(last_a) + 2) * 256) / ((inv_a == 0) ? 1 : int'(inv_a));
            span_b = ((int'(last_b) + 2) * 256) / ((inv_b == 0) ? 1 : int'(inv_b));
            if (span_a > 65535) span_a = 65535;
            if (span_b > 65535) span_b = 65535;
            pick = $urandom_range(99);
            c.weight = 16'($urandom);
            if ($urandom_range(9) < 7) begin
                c.sample_a = 16'(int'(lo_a) + int'($urandom_range(span_a)) - span_a / 8);
                c.sample_b = 16'(int'(lo_b) + int'($urandom_range(span_b)) - span_b / 8);
            end else begin
                c.sample_a = 16'($urandom);
                c.sample_b = 16'($urandom);
            end
            if (pick < 92) begin
                c.read_col = 6'($urandom_range(last_a));
                c.read_row = 6'($urandom_range(last_b));
            end else begin
                c.read_col = 6'($urandom);
                c.read_row = 6'($urandom);
            end
            if (pick < 55)      c.func = FUNC_ACC;
            else if (pick < 75) c.func = FUNC_READ;
            else if (pick < 88) c.func = FUNC_READ_CLR;
            else if (pick < 92) c.func = FUNC_UNUSED;
            else                c.func = pick[0] ? FUNC_READ : FUNC_READ_CLR;
            c.drain_first = (n == count / 2);
            cmd_backlog.push_back(c);
        end
    endtask

    initial begin
        for (int i = 0; i < COLS * ROWS; i++) bin_counts[i] = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Reset configuration, unit increments: clamping at both ends and the unused code.
        program_axes(0, 256, 63, 0, 256, 63, 0);
        queue_item(FUNC_ACC, -32768, -32768, 0, 0, 0);
        queue_item(FUNC_ACC, 32767, 32767, 0, 0, 0);
        queue_item(FUNC_ACC, 5, 7, 0, 0, 0);
        queue_item(FUNC_ACC, 5, 7, 0, 0, 0);
        queue_item(FUNC_UNUSED, 5, 7, -1, 5, 7);
        queue_item(FUNC_READ, 0, 0, 0, 5, 7);
        queue_item(FUNC_READ_CLR, 0, 0, 0, 5, 7);
        queue_item(FUNC_READ, 0, 0, 0, 5, 7);
        queue_item(FUNC_READ, 0, 0, 0, 0, 0);
        queue_item(FUNC_READ, 0, 0, 0, 63, 63);
        queue_item(FUNC_READ_CLR, 0, 0, 0, 0, 0);
        settle();

        // Extreme registers: a single bin on the first axis, zero step on the second.
        program_axes(-32768, 65535, 0, 32767, 0, 63, 1);
        queue_item(FUNC_ACC, 32767, -32768, 32767, 0, 0);
        queue_item(FUNC_ACC, -32768, 0, -32768, 0, 0);
        queue_item(FUNC_ACC, 0, 32767, 100, 0, 0);
        queue_item(FUNC_READ, 0, 0, 0, 0, 0);
        queue_item(FUNC_READ_CLR, 0, 0, 0, 0, 0);
        queue_item(FUNC_READ, 0, 0, 0, 63, 63);
        queue_item(FUNC_READ, 0, 0, 0, 63, 0);
        settle();

        // Pile large weights of both signs into one bin, with no idling on either side.
        idle_pct = 0;
        program_axes(0, 256, 63, 0, 256, 63, 1);
        for (int i = 0; i < 16; i++) queue_item(FUNC_ACC, 1, 2, 32767, 0, 0);
        queue_item(FUNC_READ, 0, 0, 0, 1, 2);
        for (int i = 0; i < 16; i++) queue_item(FUNC_ACC, 1, 2, -32768, 0, 0);
        queue_item(FUNC_ACC, 1, 2, -1, 0, 0);
        queue_item(FUNC_READ_CLR, 0, 0, 0, 1, 2);
        queue_item(FUNC_READ, 0, 0, 0, 1, 2);
        settle();
        idle_pct = 25;

        for (int p = 0; p < 6; p++) begin
            random_setup();
            random_items(90);
            settle();
        end

        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
